### rtl/xmbs_pkg.sv
`timescale 1ns / 1ps

package xmbs_pkg;

	// Block length in bytes; the byte at BLOCK_LEN-1 always closes a block.
	localparam int BLOCK_LEN = 4096;
	localparam int POS_W     = $clog2(BLOCK_LEN);
	localparam int OFF_W     = 12;
	// The position counter is wide enough for both the block and the offset field.
	localparam int CNT_W     = (POS_W > OFF_W) ? POS_W : OFF_W;

	localparam logic [7:0] CH_LT     = 8'h3C; // '<'
	localparam logic [7:0] CH_GT     = 8'h3E; // '>'
	localparam logic [7:0] CH_SLASH  = 8'h2F; // '/'
	localparam logic [7:0] CH_QUEST  = 8'h3F; // '?'
	localparam logic [7:0] CH_BANG   = 8'h21; // '!'
	localparam logic [7:0] CH_DASH   = 8'h2D; // '-'
	localparam logic [7:0] CH_LBRACK = 8'h5B; // '['
	localparam logic [7:0] CH_RBRACK = 8'h5D; // ']'

	// Bang matcher positions: 1..7 walk "![CDATA[", BANG_DASH means "!-" seen.
	localparam logic [3:0] BANG_IDLE  = 4'd0;
	localparam logic [3:0] BANG_FIRST = 4'd1;
	localparam logic [3:0] BANG_LAST  = 4'd7;
	localparam logic [3:0] BANG_DASH  = 4'd9;

	typedef enum logic [2:0] {
		MODE_SCAN  = 3'd0,
		MODE_LT    = 3'd1,
		MODE_STAG  = 3'd2,
		MODE_ETAG  = 3'd3,
		MODE_PI    = 3'd4,
		MODE_BANG  = 3'd5,
		MODE_COMM  = 3'd6,
		MODE_CDATA = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		KIND_STAG  = 3'd0,
		KIND_ETAG  = 3'd1,
		KIND_PI    = 3'd2,
		KIND_COMM  = 3'd3,
		KIND_CDATA = 3'd4,
		KIND_END   = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [OFF_W-1:0]   offset;
		logic               last;
	} event_t;

	// Up to two events produced by one byte, in order.
	typedef struct packed {
		logic [1:0] count;
		event_t     ev0;
		event_t     ev1;
	} push_t;

	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

	// Expected byte at each position of "![CDATA[".
	function automatic logic [7:0] cdata_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = CH_BANG;
			3'd1: c = CH_LBRACK;
			3'd2: c = 8'h43; // 'C'
			3'd3: c = 8'h44; // 'D'
			3'd4: c = 8'h41; // 'A'
			3'd5: c = 8'h54; // 'T'
			3'd6: c = 8'h41; // 'A'
			3'd7: c = CH_LBRACK;
			default: c = CH_BANG;
		endcase
		return c;
	endfunction

endpackage

### rtl/xml_markup_boundary_scanner_core.sv
`timescale 1ns / 1ps

// Structural prescan of XML blocks, one byte per word on the input stream. Each
// byte is held in the input register and scanned straight out of it while it
// waits there for room; its events are then written into the event queue, whose
// head drives the output word. A new byte is taken every cycle while the
// four-entry event queue has room for two events. Each byte yields at most two
// output words: a markup event (start tag at its '>', end tag at '/', PI at '?',
// comment after "!--", CDATA after "![CDATA[") and, on the last byte of a block,
// a block-end event that carries tlast. Offsets count from the start of the
// block. A block ends on an input tlast or at byte BLOCK_LEN-1 and the scanner
// then restarts clean.

module xml_markup_boundary_scanner_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // block_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [2:0] event_kind, [14:3] byte_offset, [15] zero
	output logic        m_axis_tlast    // is_last
);
	import xmbs_pkg::*;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 end_s1;
	logic                 fire;
	logic                 room;
	push_t                push;
	event_t               head;
	logic [EVQ_AW:0]      level;

	// Scan only when the queue can take both events of a byte.
	assign room          = level <= (EVQ_AW+1)'(EVQ_DEPTH - 2);
	assign fire          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	xmbs_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_s1),
		.block_end (end_s1),
		.push      (push)
	);

	xmbs_evq u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_en (fire),
		.push    (push),
		.pop     (m_axis_tready),
		.head    (head),
		.level   (level)
	);

	// Output word from the head of the queue.
	assign m_axis_tvalid = level != '0;
	assign m_axis_tdata  = {1'b0, head.offset, head.kind};
	assign m_axis_tlast  = head.last;

	// The queue never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		level <= (EVQ_AW+1)'(EVQ_DEPTH))
		else $error("event queue overfilled");

	// A block-end word is always the last word of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && head.kind == KIND_END) |-> m_axis_tlast)
		else $error("block end without last flag");

	// A byte held back for lack of room stays in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled byte lost");

	// A scanned byte always leaves the queue non-empty when it ends a block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_s1) |=> m_axis_tvalid)
		else $error("block end event missing");

endmodule

### rtl/xmbs_scan.sv
`timescale 1ns / 1ps

module xmbs_scan (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic [7:0]              data_byte,
	input  logic                    block_end,
	output xmbs_pkg::push_t         push
);
	import xmbs_pkg::*;

	mode_t            mode_q, mode_d;
	logic [3:0]       bang_q, bang_d;
	logic [7:0]       prev_q, prev2_q;
	logic [OFF_W-1:0] tag_off_q, tag_off_d;
	logic             seen_q, seen_d;
	logic [CNT_W-1:0] pos_q;

	logic             last;
	logic [OFF_W-1:0] off;
	logic             mark;
	kind_t            mark_kind;
	logic [OFF_W-1:0] mark_off;
	logic             cdata_hit;
	event_t           end_ev;
	event_t           mark_ev;

	assign last = block_end || (pos_q == CNT_W'(BLOCK_LEN - 1));
	assign off  = pos_q[OFF_W-1:0];
	assign cdata_hit = (bang_q >= BANG_FIRST) && (bang_q <= BANG_LAST) &&
		(data_byte == cdata_char(bang_q[2:0]));

	// Next scanner state for the current word.
	always_comb begin
		mode_d    = mode_q;
		bang_d    = bang_q;
		tag_off_d = tag_off_q;
		seen_d    = seen_q;
		unique case (mode_q)
			MODE_SCAN: begin
				if (data_byte == CH_LT) mode_d = MODE_LT;
			end
			MODE_LT: begin
				if (data_byte != CH_SLASH && data_byte != CH_QUEST &&
						data_byte != CH_BANG) begin
					tag_off_d = off;
					if (data_byte == CH_GT) begin
						seen_d = 1'b1;
						mode_d = MODE_SCAN;
					end else begin
						mode_d = MODE_STAG;
					end
				end else if (!seen_q) begin
					mode_d = MODE_SCAN;
				end else if (data_byte == CH_SLASH) begin
					mode_d = MODE_ETAG;
				end else if (data_byte == CH_QUEST) begin
					mode_d = MODE_PI;
				end else begin
					tag_off_d = off;
					bang_d    = BANG_FIRST;
					mode_d    = MODE_BANG;
				end
			end
			MODE_STAG: begin
				if (data_byte == CH_GT) begin
					if (prev_q != CH_SLASH) seen_d = 1'b1;
					mode_d = MODE_SCAN;
				end
			end
			MODE_ETAG: begin
				if (data_byte == CH_GT) mode_d = MODE_SCAN;
			end
			MODE_PI: begin
				if (data_byte == CH_GT && prev_q == CH_QUEST) mode_d = MODE_SCAN;
			end
			MODE_BANG: begin
				priority if (bang_q == BANG_FIRST && data_byte == CH_DASH) begin
					bang_d = BANG_DASH;
				end else if (bang_q == BANG_DASH && data_byte == CH_DASH) begin
					bang_d = BANG_IDLE;
					mode_d = MODE_COMM;
				end else if (cdata_hit) begin
					if (bang_q == BANG_LAST) begin
						bang_d = BANG_IDLE;
						mode_d = MODE_CDATA;
					end else begin
						bang_d = bang_q + 4'd1;
					end
				end else begin
					// Failed match: the same byte is looked at again as text.
					bang_d = BANG_IDLE;
					mode_d = (data_byte == CH_LT) ? MODE_LT : MODE_SCAN;
				end
			end
			MODE_COMM: begin
				if (data_byte == CH_GT && prev_q == CH_DASH && prev2_q == CH_DASH)
					mode_d = MODE_SCAN;
			end
			MODE_CDATA: begin
				if (data_byte == CH_GT && prev_q == CH_RBRACK && prev2_q == CH_RBRACK)
					mode_d = MODE_SCAN;
			end
			default: mode_d = MODE_SCAN;
		endcase
	end

	// Markup event raised by the current word, if any.
	always_comb begin
		mark      = 1'b0;
		mark_kind = KIND_STAG;
		mark_off  = tag_off_q;
		unique case (mode_q)
			MODE_LT: begin
				if (data_byte == CH_GT) begin
					mark     = 1'b1;
					mark_off = off;
				end else if (seen_q && data_byte == CH_SLASH) begin
					mark      = 1'b1;
					mark_kind = KIND_ETAG;
					mark_off  = off;
				end else if (seen_q && data_byte == CH_QUEST) begin
					mark      = 1'b1;
					mark_kind = KIND_PI;
					mark_off  = off;
				end
			end
			MODE_STAG: begin
				if (data_byte == CH_GT && prev_q != CH_SLASH) mark = 1'b1;
			end
			MODE_BANG: begin
				if (bang_q == BANG_DASH && data_byte == CH_DASH) begin
					mark      = 1'b1;
					mark_kind = KIND_COMM;
				end else if (cdata_hit && bang_q == BANG_LAST &&
						!(bang_q == BANG_FIRST && data_byte == CH_DASH)) begin
					mark      = 1'b1;
					mark_kind = KIND_CDATA;
				end
			end
			default: mark = 1'b0;
		endcase
	end

	// Pack the markup event and the block-end event in order.
	always_comb begin
		end_ev.kind    = KIND_END;
		end_ev.offset  = off;
		end_ev.last    = 1'b1;
		mark_ev.kind   = mark_kind;
		mark_ev.offset = mark_off;
		mark_ev.last   = !last;
		push.count     = 2'({1'b0, mark} + {1'b0, last});
		push.ev0       = mark ? mark_ev : end_ev;
		push.ev1       = end_ev;
	end

	// Scanner state; a block end returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SCAN;
			bang_q    <= BANG_IDLE;
			prev_q    <= '0;
			prev2_q   <= '0;
			tag_off_q <= '0;
			seen_q    <= 1'b0;
			pos_q     <= '0;
		end else if (fire) begin
			if (last) begin
				mode_q    <= MODE_SCAN;
				bang_q    <= BANG_IDLE;
				prev_q    <= '0;
				prev2_q   <= '0;
				tag_off_q <= '0;
				seen_q    <= 1'b0;
				pos_q     <= '0;
			end else begin
				mode_q    <= mode_d;
				bang_q    <= bang_d;
				prev_q    <= data_byte;
				prev2_q   <= prev_q;
				tag_off_q <= tag_off_d;
				seen_q    <= seen_d;
				pos_q     <= pos_q + CNT_W'(1);
			end
		end
	end

endmodule

### rtl/xmbs_evq.sv
`timescale 1ns / 1ps

module xmbs_evq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push_en,
	input  xmbs_pkg::push_t               push,
	input  logic                          pop,
	output xmbs_pkg::event_t              head,
	output logic [xmbs_pkg::EVQ_AW:0]     level
);
	import xmbs_pkg::*;

	event_t            slot_q [EVQ_DEPTH];
	logic [EVQ_AW-1:0] wr_q, rd_q;
	logic [EVQ_AW:0]   level_q;
	logic [1:0]        n_in;
	logic              n_out;

	assign n_in  = push_en ? push.count : 2'd0;
	assign n_out = pop && (level_q != '0);
	assign head  = slot_q[rd_q];
	assign level = level_q;

	// Event slots; two may be written in one cycle.
	always_ff @(posedge clk) begin
		if (n_in != 2'd0) slot_q[wr_q] <= push.ev0;
		if (n_in == 2'd2) slot_q[wr_q + EVQ_AW'(1)] <= push.ev1;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + EVQ_AW'(n_in);
			rd_q    <= rd_q + EVQ_AW'(n_out);
			level_q <= level_q + (EVQ_AW+1)'(n_in) - (EVQ_AW+1)'(n_out);
		end
	end

endmodule

### tb/xml_markup_boundary_scanner_core_tb.sv
`timescale 1ns / 1ps

module xml_markup_boundary_scanner_core_tb;

	import xmbs_pkg::*;

	localparam int RANDOM_ITEMS   = 1050;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int LONG_HOLD      = 400;
	localparam int HOLD_AFTER     = 200;

	// Matcher value once all of "![CDATA[" has been seen.
	localparam logic [3:0] BANG_DONE = 4'd8;

	localparam logic [7:0] CDATA_OPEN [0:7] = '{
		CH_BANG, CH_LBRACK, 8'h43, 8'h44, 8'h41, 8'h54, 8'h41, CH_LBRACK
	};

	// Receiver pacing patterns.
	typedef enum int {
		PACE_FULL,
		PACE_COIN,
		PACE_THREE_OF_FOUR,
		PACE_TRICKLE
	} pace_t;

	// One input word, optionally with its events typed in by hand.
	typedef struct {
		logic [7:0] data;
		logic       ends;
		bit         typed;
		int         count;
		event_t     first;
		event_t     second;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tlast;   // block_end
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [2:0] event_kind, [14:3] byte_offset, [15] zero
	logic        m_axis_tlast;   // is_last

	// Scanner state mirrored by the predictor.
	mode_t       scan_state;
	logic [3:0]  bang_pos;
	logic [15:0] byte_history;
	logic [11:0] markup_offset;
	logic        start_tag_seen;
	int unsigned byte_pos;

	event_t      pending_events [$];
	stim_row_t   opening_rows [$];
	logic [7:0]  markup_bytes [$];

	// What the sender currently offers, read back when the word is taken.
	stim_row_t   offered;

	int          errors;
	int          words_in;
	int          burst_left;
	bit          long_hold_done;
	event_t      head_event;
	event_t      scan_a;
	event_t      scan_b;
	int          scan_n;

	xml_markup_boundary_scanner_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic event_t mark(input kind_t kind, input logic [11:0] offset);
		event_t ev;
		ev.kind   = kind;
		ev.offset = offset;
		ev.last   = 1'b0;
		return ev;
	endfunction

	function automatic void clear_scanner();
		scan_state     = MODE_SCAN;
		bang_pos       = BANG_IDLE;
		byte_history   = '0;
		markup_offset  = '0;
		start_tag_seen = 1'b0;
		byte_pos       = 0;
	endfunction

	// Advances the scanner by one byte and returns the events it raises.
	function automatic int scan_byte(input logic [7:0] b, input logic blk_end,
			output event_t ev0, output event_t ev1);
		event_t      evs [2];
		int          n;
		logic        closes;
		logic        rescan;
		logic [11:0] off;
		logic [7:0]  prev;
		logic [7:0]  prev2;

		evs[0] = '0;
		evs[1] = '0;
		n      = 0;
		rescan = 1'b0;
		closes = blk_end || (byte_pos >= BLOCK_LEN - 1);
		off    = byte_pos[11:0];
		prev   = byte_history[7:0];
		prev2  = byte_history[15:8];

		case (scan_state)
			MODE_SCAN: begin
				if (b == CH_LT)
					scan_state = MODE_LT;
			end
			MODE_LT: begin
				if (b != CH_SLASH && b != CH_QUEST && b != CH_BANG) begin
					markup_offset = off;
					if (b == CH_GT) begin
						evs[n] = mark(KIND_STAG, off);
						n++;
						start_tag_seen = 1'b1;
						scan_state = MODE_SCAN;
					end else begin
						scan_state = MODE_STAG;
					end
				end else if (!start_tag_seen) begin
					// Markup other than a start tag is ignored until one is seen.
					scan_state = MODE_SCAN;
				end else if (b == CH_SLASH) begin
					evs[n] = mark(KIND_ETAG, off);
					n++;
					scan_state = MODE_ETAG;
				end else if (b == CH_QUEST) begin
					evs[n] = mark(KIND_PI, off);
					n++;
					scan_state = MODE_PI;
				end else begin
					markup_offset = off;
					bang_pos = BANG_FIRST;
					scan_state = MODE_BANG;
				end
			end
			MODE_STAG: begin
				if (b == CH_GT) begin
					// A self-closing tag reports nothing and does not count.
					if (prev != CH_SLASH) begin
						evs[n] = mark(KIND_STAG, markup_offset);
						n++;
						start_tag_seen = 1'b1;
					end
					scan_state = MODE_SCAN;
				end
			end
			MODE_ETAG: begin
				if (b == CH_GT)
					scan_state = MODE_SCAN;
			end
			MODE_PI: begin
				if (b == CH_GT && prev == CH_QUEST)
					scan_state = MODE_SCAN;
			end
			MODE_BANG: begin
				if (bang_pos == BANG_FIRST && b == CH_DASH) begin
					bang_pos = BANG_DASH;
				end else if (bang_pos == BANG_DASH && b == CH_DASH) begin
					evs[n] = mark(KIND_COMM, markup_offset);
					n++;
					bang_pos = BANG_IDLE;
					scan_state = MODE_COMM;
				end else if (bang_pos >= BANG_FIRST && bang_pos <= BANG_LAST &&
						b == CDATA_OPEN[bang_pos[2:0]]) begin
					bang_pos = bang_pos + 4'd1;
					if (bang_pos == BANG_DONE) begin
						evs[n] = mark(KIND_CDATA, markup_offset);
						n++;
						bang_pos = BANG_IDLE;
						scan_state = MODE_CDATA;
					end
				end else begin
					// Broken opener: the same byte is looked at again as text.
					bang_pos = BANG_IDLE;
					scan_state = MODE_SCAN;
					rescan = 1'b1;
				end
			end
			MODE_COMM: begin
				if (b == CH_GT && prev == CH_DASH && prev2 == CH_DASH)
					scan_state = MODE_SCAN;
			end
			default: begin
				if (b == CH_GT && prev == CH_RBRACK && prev2 == CH_RBRACK)
					scan_state = MODE_SCAN;
			end
		endcase

		if (rescan && b == CH_LT)
			scan_state = MODE_LT;

		byte_history = {byte_history[7:0], b};
		byte_pos++;

		if (closes) begin
			evs[n] = mark(KIND_END, off);
			n++;
		end
		if (n > 0)
			evs[n-1].last = 1'b1;
		if (closes)
			clear_scanner();

		ev0 = evs[0];
		ev1 = evs[1];
		return n;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Hands one word to the block, with a random gap between bursts.
	task automatic send_word(input stim_row_t row);
		int gap;

		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = 8'($urandom_range(0, 255));
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		@(negedge clk);
		offered       = row;
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = row.data;
		s_axis_tlast  = row.ends;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
	endtask

	function automatic void add_row(input logic [7:0] data, input logic ends,
			input bit typed, input int count, input event_t first, input event_t second);
		stim_row_t row;
		row.data   = data;
		row.ends   = ends;
		row.typed  = typed;
		row.count  = count;
		row.first  = first;
		row.second = second;
		opening_rows.push_back(row);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_row(s[i], 1'b0, 1'b0, 0, '0, '0);
	endfunction

	// Mostly letters and spaces, now and then any byte at all.
	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'($urandom_range(0, 255));
		else if (r < 3)
			return 8'h20;
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	function automatic void put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			markup_bytes.push_back(s[i]);
	endfunction

	function automatic void put_text(input int lo, input int hi);
		int n;
		n = $urandom_range(lo, hi);
		for (int i = 0; i < n; i++)
			markup_bytes.push_back(text_byte());
	endfunction

	function automatic void put_name();
		int n;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++)
			markup_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
	endfunction

	// Appends one piece of markup or text, mostly well formed.
	function automatic void add_fragment();
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			put_text(1, 6);
		end else if (r < 38) begin
			put_str("<");
			put_name();
			if ($urandom_range(0, 1) == 1) begin
				put_str(" ");
				put_name();
				put_str("=\"");
				put_text(0, 4);
				put_str("\"");
			end
			put_str(">");
		end else if (r < 46) begin
			put_str("<");
			put_name();
			put_str("/>");
		end else if (r < 60) begin
			put_str("</");
			put_name();
			put_str(">");
		end else if (r < 68) begin
			put_str("<?");
			put_text(0, 5);
			put_str("?>");
		end else if (r < 76) begin
			put_str("<!--");
			put_text(0, 6);
			put_str("-->");
		end else if (r < 84) begin
			put_str("<![CDATA[");
			put_text(0, 6);
			put_str("]]>");
		end else if (r < 92) begin
			// Opener that breaks part way; sometimes the breaking byte is a '<'.
			if ($urandom_range(0, 2) == 0) begin
				put_str("<!-");
			end else begin
				put_str("<!");
				k = $urandom_range(0, 6);
				for (int i = 0; i < k; i++)
					markup_bytes.push_back(CDATA_OPEN[i + 1]);
			end
			markup_bytes.push_back(($urandom_range(0, 2) == 0) ? CH_LT : text_byte());
		end else begin
			k = $urandom_range(1, 4);
			for (int i = 0; i < k; i++)
				markup_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// Sends one block of len bytes; a block without tlast runs to its forced end.
	task automatic send_block(input int len, input logic closes);
		stim_row_t row;

		row.typed  = 1'b0;
		row.count  = 0;
		row.first  = '0;
		row.second = '0;
		markup_bytes.delete();
		while (markup_bytes.size() < len)
			add_fragment();
		for (int i = 0; i < len; i++) begin
			row.data = markup_bytes.pop_front();
			row.ends = closes && (i == len - 1);
			send_word(row);
		end
	endtask

	// Predicts on every accepted input word and checks every output word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				words_in++;
				scan_n = scan_byte(s_axis_tdata, s_axis_tlast, scan_a, scan_b);
				if (offered.typed) begin
					scan_n = offered.count;
					scan_a = offered.first;
					scan_b = offered.second;
				end
				if (scan_n > 0)
					pending_events.push_back(scan_a);
				if (scan_n > 1)
					pending_events.push_back(scan_b);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_events.size() == 0) begin
					report_mismatch("unexpected event kind", m_axis_tdata[2:0], -1);
				end else begin
					head_event = pending_events.pop_front();
					if (m_axis_tdata[2:0] != head_event.kind)
						report_mismatch("event_kind", m_axis_tdata[2:0], head_event.kind);
					if (m_axis_tdata[14:3] != head_event.offset)
						report_mismatch("byte_offset", m_axis_tdata[14:3], head_event.offset);
					if (m_axis_tlast != head_event.last)
						report_mismatch("is_last", m_axis_tlast, head_event.last);
				end
			end
		end
	end

	// Receiver: changes pace every segment, with one long hold-off.
	initial begin
		pace_t pace;
		int    span;
		int    phase;

		m_axis_tready = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && words_in >= HOLD_AFTER) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold_done = 1'b1;
			end
			pace = pace_t'($urandom_range(0, 3));
			span = $urandom_range(16, 128);
			for (phase = 0; phase < span; phase++) begin
				@(negedge clk);
				case (pace)
					PACE_FULL:          m_axis_tready = 1'b1;
					PACE_COIN:          m_axis_tready = 1'($urandom_range(0, 1));
					PACE_THREE_OF_FOUR: m_axis_tready = (phase % 4) != 3;
					default:            m_axis_tready = ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Ends the run when no word moves on either side for too long.
	initial begin
		int quiet;

		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int  random_items;
		int  len;
		int  r;
		bit  forced_done;

		errors        = 0;
		words_in      = 0;
		burst_left    = 0;
		offered       = '{default: '0};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		clear_scanner();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed opening: single-byte blocks at the byte extremes, then one block
		// that walks ignored markup before the first tag, a PI and a comment whose
		// closers overlap their openers, a broken opener whose '<' starts a new tag,
		// an end tag, and a CDATA opener completed by the block's final byte.
		add_row(8'h00, 1'b1, 1'b1, 1, event_t'{KIND_END, 12'd0, 1'b1}, '0);
		add_row(8'hFF, 1'b1, 1'b1, 1, event_t'{KIND_END, 12'd0, 1'b1}, '0);
		add_text("</<");
		add_row(CH_GT, 1'b0, 1'b1, 1, event_t'{KIND_STAG, 12'd3, 1'b1}, '0);
		add_text("<?><!--><!<>");
		add_text("</><![CDATA");
		add_row(CH_LBRACK, 1'b1, 1'b1, 2, event_t'{KIND_CDATA, 12'd20, 1'b0},
			event_t'{KIND_END, 12'd27, 1'b1});
		foreach (opening_rows[i])
			send_word(opening_rows[i]);

		// Random blocks of well-formed markup with noise, cut at random lengths;
		// one block runs without tlast until the length limit closes it.
		random_items = 0;
		forced_done  = 1'b0;
		while (random_items < RANDOM_ITEMS) begin
			if (!forced_done && random_items >= 400) begin
				send_block(BLOCK_LEN, 1'b0);
				forced_done = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 5)
				len = 1;
			else if (r < 75)
				len = $urandom_range(2, 40);
			else
				len = $urandom_range(41, 160);
			send_block(len, 1'b1);
			random_items += len;
		end

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
